/* src/cpc_pkg.sv */
// Shared types and constants for the contact point cache.
// Used by cpc_ctrl, cpc_datapath and contact_point_cache; no dependencies.
`default_nettype none

package cpc_pkg;

  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;
  localparam int CNT_W   = 3;
  localparam int DEPTH_W = 24;
  localparam int THR_W   = 24;
  localparam int AB_W    = 25;   // area edge components after the pre-shift
  localparam int MUL_W   = 34;   // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int C_W     = 52;   // cross product component
  localparam int MAG_W   = 51;
  localparam int LO_W    = 26;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int ACC_W   = 112;
  localparam int OUT_W   = 8;
  localparam logic [THR_W-1:0] THR_RESET = 24'd410;

  typedef enum logic [1:0] {
    ACT_REFRESH = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_EVICT   = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_THR, ST_DRD, ST_DIST, ST_DWAIT, ST_DCMP, ST_DECIDE, ST_DEEP,
    ST_AB0, ST_AB1, ST_AB2, ST_AB3, ST_CR0, ST_CR1, ST_CWAIT, ST_SQ,
    ST_AWAIT, ST_ACMP, ST_PICK, ST_WRITE
  } state_e;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_THR, MOP_DIST, MOP_CROSS_A, MOP_CROSS_B,
    MOP_SQ_LL, MOP_SQ_HL, MOP_SQ_HH
  } mul_op_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_LATCH_H, OP_LOAD_B, OP_LOAD_A,
    OP_CMP_DIST, OP_FIND_DEEP, OP_CMP_AREA, OP_WRITE
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    mul_op_e             mop;
    logic                rd_en;
    logic [SLOT_W-1:0]   raddr;
    logic [1:0]          k;
    logic [SLOT_W-1:0]   idx;
    logic [SLOT_W-1:0]   widx;
  } dp_cmd_t;

  typedef struct packed {
    logic                near_found;
    logic [SLOT_W-1:0]   near_idx;
    logic [SLOT_W-1:0]   pick_idx;
  } dp_status_t;

  // Quad corners used for the area term of each candidate slot.
  function automatic logic [SLOT_W-1:0] area_a(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] area_bh(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] r;
    case (i)
      2'd3:    r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] area_bl(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] r;
    case (i)
      2'd0, 2'd1: r = 2'd2;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/cpc_datapath.sv */
// Datapath of the contact point cache: slot store, shared multiplier,
// accumulators and compare logic. Depends on cpc_pkg.
`default_nettype none

module cpc_datapath #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [cpc_pkg::THR_W-1:0]     cfg_wr_data_i,
  input  wire logic signed [COORD_BITS-1:0]  in_x_i,
  input  wire logic signed [COORD_BITS-1:0]  in_y_i,
  input  wire logic signed [COORD_BITS-1:0]  in_z_i,
  input  wire logic signed [cpc_pkg::DEPTH_W-1:0] in_depth_i,
  input  wire cpc_pkg::dp_cmd_t              cmd_i,
  output cpc_pkg::dp_status_t                status_o
);
  import cpc_pkg::*;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int AREA_SHIFT = (COORD_BITS > 24) ? (COORD_BITS - 24) : 0;
  localparam int ROW_W      = 3 * COORD_BITS;

  logic [ROW_W-1:0]                pos_mem [SLOTS];
  logic [ROW_W-1:0]                rdata_q;
  logic [ROW_W-1:0]                hrow_q;
  logic signed [DEPTH_W-1:0]       depth_q [SLOTS];
  logic signed [COORD_BITS-1:0]    p_q [3];
  logic signed [DEPTH_W-1:0]       dep_q;
  logic signed [AB_W-1:0]          a_q [3];
  logic signed [AB_W-1:0]          b_q [3];
  logic [THR_W-1:0]                thr_q;
  logic signed [PROD_W-1:0]        prod_q, prod_d;
  mul_op_e                         mop_q;
  logic                            clr_q;
  logic [ACC_W-1:0]                s_q, s_d, best_q, best_d, area_best_q, area_best_d;
  logic signed [C_W-1:0]           c_q, c_d;
  logic                            near_found_q, near_found_d;
  logic [SLOT_W-1:0]               near_idx_q, near_idx_d, pick_q, pick_d;
  logic                            deep_v_q, deep_v_d;
  logic [SLOT_W-1:0]               deep_q, deep_d;

  logic signed [COORD_BITS-1:0]    rd_c [3];
  logic signed [COORD_BITS-1:0]    h_c [3];
  logic signed [DIFF_W-1:0]        dist_c;
  logic signed [MUL_W-1:0]         op_a, op_b;
  logic [1:0]                      u_idx, v_idx;
  logic signed [C_W-1:0]           c_abs;
  logic [LO_W-1:0]                 c_lo;
  logic [HI_W-1:0]                 c_hi;
  logic [ACC_W-1:0]                prod_u, s50, area_term;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_c[k] = rdata_q[k*COORD_BITS +: COORD_BITS];
      h_c[k]  = hrow_q[k*COORD_BITS +: COORD_BITS];
    end
  end

  assign dist_c = DIFF_W'(rd_c[cmd_i.k]) - DIFF_W'(p_q[cmd_i.k]);
  assign c_abs  = c_q[C_W-1] ? -c_q : c_q;
  assign c_lo   = c_abs[LO_W-1:0];
  assign c_hi   = c_abs[MAG_W-1:LO_W];

  always_comb begin
    case (cmd_i.k)
      2'd0:    begin u_idx = 2'd1; v_idx = 2'd2; end
      2'd1:    begin u_idx = 2'd2; v_idx = 2'd0; end
      default: begin u_idx = 2'd0; v_idx = 2'd1; end
    endcase
  end

  // Operand select for the one shared multiplier
  always_comb begin
    case (cmd_i.mop)
      MOP_THR: begin
        op_a = {{(MUL_W-THR_W){1'b0}}, thr_q};
        op_b = {{(MUL_W-THR_W){1'b0}}, thr_q};
      end
      MOP_DIST: begin
        op_a = MUL_W'(dist_c);
        op_b = MUL_W'(dist_c);
      end
      MOP_CROSS_A: begin
        op_a = MUL_W'(a_q[u_idx]);
        op_b = MUL_W'(b_q[v_idx]);
      end
      MOP_CROSS_B: begin
        op_a = MUL_W'(a_q[v_idx]);
        op_b = MUL_W'(b_q[u_idx]);
      end
      MOP_SQ_LL: begin
        op_a = {{(MUL_W-LO_W){1'b0}}, c_lo};
        op_b = {{(MUL_W-LO_W){1'b0}}, c_lo};
      end
      MOP_SQ_HL: begin
        op_a = {{(MUL_W-HI_W){1'b0}}, c_hi};
        op_b = {{(MUL_W-LO_W){1'b0}}, c_lo};
      end
      MOP_SQ_HH: begin
        op_a = {{(MUL_W-HI_W){1'b0}}, c_hi};
        op_b = {{(MUL_W-HI_W){1'b0}}, c_hi};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d    = op_a * op_b;
  assign prod_u    = ACC_W'(prod_q[PROD_W-2:0]);
  assign s50       = (s_q << 5) + (s_q << 4) + (s_q << 1);
  assign area_term = (deep_v_q && (deep_q == cmd_i.idx)) ? '0 : s_q;

  always_comb begin
    logic signed [DEPTH_W-1:0] md;
    s_d          = s_q;
    best_d       = best_q;
    c_d          = c_q;
    near_found_d = near_found_q;
    near_idx_d   = near_idx_q;
    area_best_d  = area_best_q;
    pick_d       = pick_q;
    deep_v_d     = deep_v_q;
    deep_d       = deep_q;
    md           = dep_q;

    // accumulate the product issued in the previous cycle
    case (mop_q)
      MOP_THR:     best_d = prod_u;
      MOP_DIST:    s_d = (clr_q ? '0 : s_q) + prod_u;
      MOP_CROSS_A: c_d = C_W'(prod_q);
      MOP_CROSS_B: c_d = c_q - C_W'(prod_q);
      MOP_SQ_LL:   s_d = s_q + prod_u;
      MOP_SQ_HL:   s_d = s_q + (prod_u << (LO_W + 1));
      MOP_SQ_HH:   s_d = s_q + (prod_u << (2 * LO_W));
      default:     ;
    endcase

    case (cmd_i.op)
      OP_LOAD_IN:  near_found_d = 1'b0;
      OP_LOAD_A:   s_d = '0;
      OP_CMP_DIST: begin
        if (s50 < best_q) begin
          best_d       = s50;
          near_found_d = 1'b1;
          near_idx_d   = cmd_i.idx;
        end
      end
      OP_FIND_DEEP: begin
        // running minimum, strict: earliest deepest slot wins
        deep_v_d    = 1'b0;
        deep_d      = '0;
        area_best_d = '0;
        pick_d      = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (depth_q[i] < md) begin
            md       = depth_q[i];
            deep_v_d = 1'b1;
            deep_d   = SLOT_W'(i);
          end
        end
      end
      OP_CMP_AREA: begin
        if (area_best_q < area_term) begin
          area_best_d = area_term;
          pick_d      = cmd_i.idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_RESET;
      mop_q        <= MOP_NONE;
      clr_q        <= 1'b0;
      near_found_q <= 1'b0;
      deep_v_q     <= 1'b0;
    end else begin
      if (cfg_wr_en_i) thr_q <= cfg_wr_data_i;
      mop_q        <= cmd_i.mop;
      clr_q        <= (cmd_i.k == 2'd0);
      near_found_q <= near_found_d;
      deep_v_q     <= deep_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    s_q         <= s_d;
    best_q      <= best_d;
    c_q         <= c_d;
    near_idx_q  <= near_idx_d;
    area_best_q <= area_best_d;
    pick_q      <= pick_d;
    deep_q      <= deep_d;
    if (cmd_i.rd_en) rdata_q <= pos_mem[cmd_i.raddr];
    case (cmd_i.op)
      OP_LOAD_IN: begin
        p_q[0] <= in_x_i;
        p_q[1] <= in_y_i;
        p_q[2] <= in_z_i;
        dep_q  <= in_depth_i;
      end
      OP_LATCH_H: hrow_q <= rdata_q;
      OP_LOAD_B: begin
        for (int k = 0; k < 3; k++) begin
          b_q[k] <= AB_W'((DIFF_W'(h_c[k]) - DIFF_W'(rd_c[k])) >>> AREA_SHIFT);
        end
      end
      OP_LOAD_A: begin
        for (int k = 0; k < 3; k++) begin
          a_q[k] <= AB_W'((DIFF_W'(p_q[k]) - DIFF_W'(rd_c[k])) >>> AREA_SHIFT);
        end
      end
      OP_WRITE: begin
        pos_mem[cmd_i.widx] <= {p_q[2], p_q[1], p_q[0]};
        depth_q[cmd_i.widx] <= dep_q;
      end
      default: ;
    endcase
  end

  assign status_o = '{near_found: near_found_q, near_idx: near_idx_q, pick_idx: pick_q};

endmodule

`default_nettype wire

/* src/cpc_ctrl.sv */
// Sequencer of the contact point cache: steps the datapath through match,
// append and area eviction, and holds the result word. Depends on cpc_pkg.
`default_nettype none

module cpc_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [cpc_pkg::SLOT_W-1:0]       out_slot_o,
  output cpc_pkg::action_e                 out_action_o,
  output logic [cpc_pkg::CNT_W-1:0]        out_count_o,
  output cpc_pkg::dp_cmd_t                 cmd_o,
  input  wire cpc_pkg::dp_status_t         status_i
);
  import cpc_pkg::*;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] i_q, i_d, widx_q, widx_d;
  logic [1:0]        k_q, k_d, m_q, m_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, out_cnt_q, out_cnt_d;
  action_e           act_q, act_d, out_act_q, out_act_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    k_q        <= k_d;
    m_q        <= m_d;
    widx_q     <= widx_d;
    act_q      <= act_d;
    out_slot_q <= out_slot_d;
    out_act_q  <= out_act_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    m_d         = m_q;
    cnt_d       = cnt_q;
    widx_d      = widx_q;
    act_d       = act_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_slot_d  = out_slot_q;
    out_act_d   = out_act_q;
    out_cnt_d   = out_cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '{op: OP_NONE, mop: MOP_NONE, default: '0};

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD_IN;
          state_d  = ST_THR;
        end
      end
      ST_THR: begin
        cmd_o.mop = MOP_THR;
        i_d       = '0;
        state_d   = (cnt_q == '0) ? ST_DECIDE : ST_DRD;
      end
      ST_DRD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.raddr = i_q;
        k_d         = 2'd0;
        state_d     = ST_DIST;
      end
      ST_DIST: begin
        cmd_o.mop = MOP_DIST;
        cmd_o.k   = k_q;
        if (k_q == 2'd2) state_d = ST_DWAIT;
        else             k_d = k_q + 2'd1;
      end
      ST_DWAIT: state_d = ST_DCMP;
      ST_DCMP: begin
        cmd_o.op  = OP_CMP_DIST;
        cmd_o.idx = i_q;
        if (({1'b0, i_q} + 3'd1) < cnt_q) begin
          i_d     = i_q + 2'd1;
          state_d = ST_DRD;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.near_found) begin
          widx_d  = status_i.near_idx;
          act_d   = ACT_REFRESH;
          state_d = ST_WRITE;
        end else if (cnt_q < CNT_W'(SLOTS)) begin
          widx_d  = cnt_q[SLOT_W-1:0];
          act_d   = ACT_APPEND;
          cnt_d   = cnt_q + 3'd1;
          state_d = ST_WRITE;
        end else begin
          state_d = ST_DEEP;
        end
      end
      ST_DEEP: begin
        cmd_o.op = OP_FIND_DEEP;
        i_d      = '0;
        state_d  = ST_AB0;
      end
      ST_AB0: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.raddr = area_bh(i_q);
        state_d     = ST_AB1;
      end
      ST_AB1: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.raddr = area_bl(i_q);
        cmd_o.op    = OP_LATCH_H;
        state_d     = ST_AB2;
      end
      ST_AB2: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.raddr = area_a(i_q);
        cmd_o.op    = OP_LOAD_B;
        state_d     = ST_AB3;
      end
      ST_AB3: begin
        cmd_o.op = OP_LOAD_A;
        m_d      = 2'd0;
        state_d  = ST_CR0;
      end
      ST_CR0: begin
        cmd_o.mop = MOP_CROSS_A;
        cmd_o.k   = m_q;
        state_d   = ST_CR1;
      end
      ST_CR1: begin
        cmd_o.mop = MOP_CROSS_B;
        cmd_o.k   = m_q;
        state_d   = ST_CWAIT;
      end
      ST_CWAIT: begin
        k_d     = 2'd0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        case (k_q)
          2'd0:    cmd_o.mop = MOP_SQ_LL;
          2'd1:    cmd_o.mop = MOP_SQ_HL;
          default: cmd_o.mop = MOP_SQ_HH;
        endcase
        if (k_q == 2'd2) begin
          if (m_q == 2'd2) begin
            state_d = ST_AWAIT;
          end else begin
            m_d     = m_q + 2'd1;
            state_d = ST_CR0;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_AWAIT: state_d = ST_ACMP;
      ST_ACMP: begin
        cmd_o.op  = OP_CMP_AREA;
        cmd_o.idx = i_q;
        if (i_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_PICK;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = ST_AB0;
        end
      end
      ST_PICK: begin
        widx_d  = status_i.pick_idx;
        act_d   = ACT_EVICT;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_WRITE;
          cmd_o.widx  = widx_q;
          out_valid_d = 1'b1;
          out_slot_d  = widx_q;
          out_act_d   = act_q;
          out_cnt_d   = cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_slot_o   = out_slot_q;
  assign out_action_o = out_act_q;
  assign out_count_o  = out_cnt_q;

endmodule

`default_nettype wire

/* src/contact_point_cache.sv */
// A refresh or append word walks the n valid slots; an eviction (all four
// slots full) also sweeps the area term of all four candidates. A new word
// is taken only once the last result is registered. The pace is set by the
// single shared multiplier that all squares and cross products go through.
// Reset (rst_ni, asynchronous, active low) empties the cache, restores the
// breaking threshold to 410 and drops any pending result word.
// Top level; instantiates cpc_ctrl and cpc_datapath, depends on cpc_pkg.
`default_nettype none

module contact_point_cache #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_wr_en_i,
  input  wire logic [cpc_pkg::THR_W-1:0] cfg_wr_data_i,   // breaking_threshold
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // local_x, local_y, local_z, pen_depth (from bit 0 up), zero filled
  input  wire logic [((3*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [cpc_pkg::OUT_W-1:0]      m_axis_tdata     // slot, action, held_count
);
  import cpc_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [SLOT_W-1:0] out_slot;
  action_e           out_action;
  logic [CNT_W-1:0]  out_count;

  // Controller: walks the slots for the nearest match, then either appends
  // or runs the area sweep over all four candidates.
  cpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_slot_o   (out_slot),
    .out_action_o (out_action),
    .out_count_o  (out_count),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // Datapath: slot store, multiplier and the distance and area compares.
  cpc_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_x_i        ($signed(s_axis_tdata[COORD_BITS-1:0])),
    .in_y_i        ($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
    .in_z_i        ($signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .in_depth_i    ($signed(s_axis_tdata[3*COORD_BITS+DEPTH_W-1:3*COORD_BITS])),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  // Pack the result word: slot in the low bits, then action, then count.
  assign m_axis_tdata = {1'b0, out_count, out_action, out_slot};

  // Count never runs past the number of slots.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:4] <= 3'd4))
    else $error("held count above slot total");

  // Hold off further words while one is being worked on.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while busy");

  // An append lands in the slot just past the previous fill level.
  a_append_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[3:2] == ACT_APPEND))
      |-> (m_axis_tdata[6:4] == ({1'b0, m_axis_tdata[1:0]} + 3'd1)))
    else $error("append slot does not match count");

  // Eviction only happens with every slot full.
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[3:2] == ACT_EVICT)) |-> (m_axis_tdata[6:4] == 3'd4))
    else $error("eviction with free slots");

endmodule

`default_nettype wire
